// ===== rtl/core/spcf_pkg.sv =====
// Package: shared constants and helpers of the sprite projection core.
`timescale 1ns / 1ps
package spcf_pkg;

	localparam int SpriteCountDefault = 256;
	localparam int CfgIndexWidth = 3;
	localparam int CfgDataWidth = 31;
	localparam int DivStages = 32;

	localparam logic [CfgIndexWidth-1:0] CfgNear    = 3'd0;
	localparam logic [CfgIndexWidth-1:0] CfgFar     = 3'd1;
	localparam logic [CfgIndexWidth-1:0] CfgPersp   = 3'd2;
	localparam logic [CfgIndexWidth-1:0] CfgCenterX = 3'd3;
	localparam logic [CfgIndexWidth-1:0] CfgCenterY = 3'd4;
	localparam logic [CfgIndexWidth-1:0] CfgWinW    = 3'd5;
	localparam logic [CfgIndexWidth-1:0] CfgWinH    = 3'd6;
	localparam logic [CfgIndexWidth-1:0] CfgFog     = 3'd7;

	localparam logic [4:0] LoadViewLast = 5'd11;
	localparam logic [4:0] LoadObjLast  = 5'd23;
	localparam logic [4:0] LoadViewDist = 5'd24;
	localparam logic [4:0] LoadBoxFirst = 5'd25;
	localparam logic [4:0] LoadBoxLast  = 5'd28;

	localparam logic signed [15:0] ShadeCull    = 16'sd8191;
	localparam logic signed [15:0] ShadeNeutral = 16'sd4096;

	// Converts 24-bit colour, red in the low byte, to 15-bit RGB.
	function automatic logic [15:0] rgb15(input logic [23:0] c);
		rgb15 = {1'b0, c[7:3], c[15:11], c[23:19]};
	endfunction

endpackage

// ===== rtl/core/sprite_project_cull_fog_core.sv =====
// Top level: sprite transform, depth clip, projection, screen cull and fog.
`timescale 1ns / 1ps
// Usage.
// A request is transferred at a rising edge where start is high and busy is low.
// req_type 0 draws a sprite, req_type 1 loads one state word (pos_x is the word).
// Every request gives exactly one result, shown for a single cycle with done high;
// the receiver cannot hold a result off, so nothing in the pipe ever stalls.
// Draw requests flow through a fixed pipeline: subtract, nine 32x32 products,
// sums, clip tests and four box offsets, a 32-stage divider (one quotient bit per
// stage), four signed divisions by the perspective quotient (each a 32-stage
// divider), then cull, fog and colour.  A draw passes through five front stages,
// two 32-stage dividers with a stage between them, the screen stage and the
// output register.
// A new draw may be transferred every cycle.
// A load writes its state word on the transfer edge and its result is shown in
// the very next cycle.  busy is raised for a load while anything is in flight,
// so a later draw never sees state that changed underneath an earlier one; the
// load is taken in the cycle after the last earlier result is shown.  Draws are
// never held.  Reset clears the pipeline valid bits, the matrices, view distance
// and the registers to their defaults.  Sprite boxes are undefined until loaded.
// Configuration is written with cfg_we, cfg_index and cfg_data; the user must do
// so only while idle, since the block itself does not enforce it.
module sprite_project_cull_fog_core
	import spcf_pkg::*;
#(
	parameter int SPRITE_COUNT = SpriteCountDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	output logic                     done,
	input  logic                     cfg_we,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data,
	input  logic                     req_type,
	input  logic signed [31:0]       pos_x,
	input  logic signed [31:0]       pos_y,
	input  logic signed [31:0]       pos_z,
	input  logic [7:0]               sprite_index,
	input  logic signed [15:0]       shade_in,
	input  logic signed [15:0]       scale_factor,
	input  logic                     world_space,
	input  logic                     scaled_mode,
	input  logic                     fog_mode,
	input  logic [23:0]              rgb_colour,
	input  logic [4:0]               load_index,
	output logic                     visible,
	output logic signed [31:0]       depth,
	output logic signed [31:0]       left,
	output logic signed [31:0]       top,
	output logic signed [31:0]       right,
	output logic signed [31:0]       bottom,
	output logic [7:0]               sprite_out,
	output logic signed [15:0]       shade_out,
	output logic                     colour_kind,
	output logic signed [31:0]       load_value
);
	localparam int SlotW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
	localparam int Lat = 5 + 2 * DivStages + 2;
	localparam logic [16:0] SlotRecip = 17'((65536 + SPRITE_COUNT - 1) / SPRITE_COUNT);

	typedef struct packed {
		logic        load;
		logic        world;
		logic        scaled;
		logic        fog;
		logic [7:0]  idx;
		logic signed [15:0] shade;
		logic signed [15:0] scale;
		logic [23:0] rgb;
		logic [31:0] lval;
	} ctl_t;

	// Configuration registers.
	logic [30:0] near_q, far_q;
	logic [15:0] persp_q;
	logic [11:0] cx_q, cy_q;
	logic [12:0] ww_q, wh_q;
	logic [14:0] fog_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= 31'd327680;
			far_q <= 31'd335544320;
			persp_q <= 16'd320;
			cx_q <= 12'd320;
			cy_q <= 12'd240;
			ww_q <= 13'd640;
			wh_q <= 13'd480;
			fog_q <= 15'd12288;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgNear:    near_q <= cfg_data;
				CfgFar:     far_q <= cfg_data;
				CfgPersp:   persp_q <= cfg_data[15:0];
				CfgCenterX: cx_q <= cfg_data[11:0];
				CfgCenterY: cy_q <= cfg_data[11:0];
				CfgWinW:    ww_q <= cfg_data[12:0];
				CfgWinH:    wh_q <= cfg_data[12:0];
				CfgFog:     fog_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Matrix and view distance state, written by load requests.
	logic [31:0] vm_q [12];
	logic [31:0] om_q [12];
	logic [31:0] vd_q;
	logic        accept;
	logic        is_load;
	logic [SlotW-1:0] slot;
	logic [31:0] lval;

	assign accept = start && !busy;
	assign is_load = accept && req_type;

	if (SPRITE_COUNT >= 256) begin : g_slot_direct
		assign slot = SlotW'(sprite_index);
	end else begin : g_slot_wrap
		// The index times the rounded-up reciprocal of the count gives the exact
		// quotient for every 8-bit index, so the wrap is a multiply and a subtract.
		logic [24:0] prod;
		logic [8:0]  quo;
		logic [20:0] back;
		assign prod = 25'(sprite_index) * 25'(SlotRecip);
		assign quo = prod[24:16];
		assign back = 21'(quo) * 21'(SPRITE_COUNT);
		assign slot = SlotW'(8'(21'(sprite_index) - back));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 12; i++) begin
				vm_q[i] <= '0;
				om_q[i] <= '0;
			end
			vd_q <= '0;
		end else if (is_load) begin
			if (load_index <= LoadViewLast) begin
				vm_q[load_index[3:0]] <= pos_x;
			end else if (load_index <= LoadObjLast) begin
				om_q[4'(load_index - 5'd12)] <= pos_x;
			end else if (load_index == LoadViewDist) begin
				vd_q <= pos_x;
			end
		end
	end

	always_comb begin
		if (load_index <= LoadViewDist) begin
			lval = pos_x;
		end else if (load_index <= LoadBoxLast) begin
			lval = {{16{pos_x[15]}}, pos_x[15:0]};
		end else begin
			lval = '0;
		end
	end

	// Box store: one RAM per corner, each read once per draw.
	logic [15:0] box_rd [4];
	for (genvar c = 0; c < 4; c++) begin : g_box
		spcf_ram #(.Width(16), .Depth(1 << SlotW)) u_ram (
			.clk   (clk),
			.we    (is_load && load_index == LoadBoxFirst + 5'(c)),
			.waddr (slot),
			.wdata (pos_x[15:0]),
			.raddr (slot),
			.rdata (box_rd[c])
		);
	end

	// In-flight count: loads wait until all earlier requests have left.
	logic [$clog2(Lat+2)-1:0] inflight_q;
	logic                     in_done;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + ($bits(inflight_q))'(accept) -
				($bits(inflight_q))'(in_done);
		end
	end
	assign busy = start && req_type && (inflight_q != '0);

	// Stage 1: subtract camera, capture request.
	logic        v_s1;
	ctl_t        c_s1;
	logic [31:0] x_s1, y_s1, z_s1;
	ctl_t        c_in;
	always_comb begin
		c_in.load = req_type;
		c_in.world = world_space;
		c_in.scaled = scaled_mode;
		c_in.fog = fog_mode;
		c_in.idx = sprite_index;
		c_in.shade = shade_in;
		c_in.scale = scale_factor;
		c_in.rgb = rgb_colour;
		c_in.lval = lval;
	end
	// Only draws enter the pipeline; a load reports straight from the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= accept && !req_type;
	end
	always_ff @(posedge clk) begin
		c_s1 <= c_in;
		x_s1 <= world_space ? pos_x - vm_q[3] : pos_x;
		y_s1 <= world_space ? pos_y - vm_q[7] : pos_y;
		z_s1 <= world_space ? pos_z - vm_q[11] : pos_z;
	end

	// Stage 2: range test and nine products.
	logic        v_s2, boxout_s2;
	ctl_t        c_s2;
	logic [31:0] p_s2 [9];
	logic [31:0] t_s2 [3];
	logic [15:0] b_s2 [4];
	logic signed [31:0] nvd, vds;
	logic        bo1;
	assign vds = vd_q;
	assign nvd = 32'(0) - vd_q;
	assign bo1 = $signed(x_s1) < nvd || $signed(x_s1) > vds || $signed(y_s1) < nvd ||
		$signed(y_s1) > vds || $signed(z_s1) < nvd || $signed(z_s1) > vds;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		c_s2 <= c_s1;
		boxout_s2 <= c_s1.world && bo1;
		for (int r = 0; r < 3; r++) begin
			p_s2[3*r]   <= x_s1 * (c_s1.world ? vm_q[4*r]   : om_q[4*r]);
			p_s2[3*r+1] <= y_s1 * (c_s1.world ? vm_q[4*r+1] : om_q[4*r+1]);
			p_s2[3*r+2] <= z_s1 * (c_s1.world ? vm_q[4*r+2] : om_q[4*r+2]);
			t_s2[r] <= c_s1.world ? 32'd0 : om_q[4*r+3];
		end
		for (int c = 0; c < 4; c++) b_s2[c] <= box_rd[c];
	end

	// Stage 3: sums.
	logic        v_s3, boxout_s3;
	ctl_t        c_s3;
	logic [31:0] xv_s3, yv_s3, zv_s3;
	logic [15:0] b_s3 [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		c_s3 <= c_s2;
		boxout_s3 <= boxout_s2;
		xv_s3 <= p_s2[0] + p_s2[1] + p_s2[2] + t_s2[0];
		yv_s3 <= p_s2[3] + p_s2[4] + p_s2[5] + t_s2[1];
		zv_s3 <= p_s2[6] + p_s2[7] + p_s2[8] + t_s2[2];
		b_s3 <= b_s2;
	end

	// Stage 4: depth clip; corner offsets.
	logic        v_s4, rej_s4;
	ctl_t        c_s4;
	logic [31:0] xv_s4, yv_s4, zv_s4;
	logic [31:0] co_s4 [4];
	logic        clip;
	always_comb begin
		if (c_s3.world) begin
			clip = $signed(zv_s3) < $signed({1'b0, near_q}) ||
				$signed(zv_s3) >= $signed({1'b0, far_q});
		end else begin
			clip = $signed(zv_s3) < $signed({1'b0, near_q}) ||
				$signed(zv_s3) > $signed({1'b0, far_q});
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		c_s4 <= c_s3;
		rej_s4 <= boxout_s3 || clip || persp_q == '0;
		xv_s4 <= xv_s3;
		yv_s4 <= yv_s3;
		zv_s4 <= zv_s3;
		for (int c = 0; c < 4; c++) begin
			if (c_s3.scaled) begin
				co_s4[c] <= 32'(32'($signed(c_s3.scale)) * 32'($signed(b_s3[c]))) << 6;
			end else begin
				co_s4[c] <= 32'($signed(b_s3[c])) << 14;
			end
		end
	end

	// Stage 5: numerators.
	logic        v_s5, rej_s5;
	ctl_t        c_s5;
	logic [31:0] zv_s5;
	logic [31:0] n_s5 [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		c_s5 <= c_s4;
		rej_s5 <= rej_s4;
		zv_s5 <= zv_s4;
		n_s5[0] <= co_s4[0] + xv_s4;
		n_s5[1] <= co_s4[1] + yv_s4;
		n_s5[2] <= co_s4[2] + xv_s4;
		n_s5[3] <= co_s4[3] + yv_s4;
	end

	// Perspective quotient; side data travel as the divider tag.
	localparam int TagA = $bits(ctl_t) + 1 + 32 + 128;
	logic            va;
	logic [31:0]     za;
	logic [TagA-1:0] taga;
	spcf_div #(.NumW(32), .DenW(16), .TagW(TagA)) u_div_z (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s5), .num(zv_s5), .den(persp_q),
		.tag_in({c_s5, rej_s5, zv_s5, n_s5[0], n_s5[1], n_s5[2], n_s5[3]}),
		.out_valid(va), .quot(za), .tag_out(taga)
	);
	ctl_t        c_a;
	logic        rej_a;
	logic [31:0] zv_a;
	logic [31:0] n_a [4];
	assign {c_a, rej_a, zv_a, n_a[0], n_a[1], n_a[2], n_a[3]} = taga;

	// Stage 6: magnitudes for the signed divisions.
	logic        v_s6, rej_s6;
	ctl_t        c_s6;
	logic [31:0] zv_s6, zmag_s6;
	logic [31:0] nmag_s6 [4];
	logic [3:0]  neg_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= va;
	end
	always_ff @(posedge clk) begin
		c_s6 <= c_a;
		rej_s6 <= rej_a || za == '0;
		zv_s6 <= zv_a;
		zmag_s6 <= za[31] ? 32'(0) - za : za;
		for (int c = 0; c < 4; c++) begin
			nmag_s6[c] <= n_a[c][31] ? 32'(0) - n_a[c] : n_a[c];
			neg_s6[c] <= n_a[c][31] ^ za[31];
		end
	end

	// Four corner divisions, truncating toward zero.
	localparam int TagB = $bits(ctl_t) + 1 + 32 + 4;
	logic        vb [4];
	logic [31:0] qb [4];
	logic [TagB-1:0] tagb [4];
	for (genvar c = 0; c < 4; c++) begin : g_cdiv
		spcf_div #(.NumW(32), .DenW(32), .TagW(TagB)) u_div (
			.clk(clk), .arst_n(arst_n), .in_valid(v_s6), .num(nmag_s6[c]),
			.den(zmag_s6), .tag_in({c_s6, rej_s6, zv_s6, neg_s6}),
			.out_valid(vb[c]), .quot(qb[c]), .tag_out(tagb[c])
		);
	end
	ctl_t        c_b;
	logic        rej_b;
	logic [31:0] zv_b;
	logic [3:0]  neg_b;
	assign {c_b, rej_b, zv_b, neg_b} = tagb[0];

	// Stage 7: screen coordinates and fog sum.
	logic        v_s7, rej_s7, fogcull_s7;
	ctl_t        c_s7;
	logic [31:0] zv_s7;
	logic signed [31:0] sc_s7 [4];
	logic signed [15:0] sh_s7;
	logic [31:0] qs [4];
	logic [31:0] fadd;
	logic signed [15:0] fsh;
	logic        fog_on;
	always_comb begin
		for (int c = 0; c < 4; c++) qs[c] = neg_b[c] ? 32'(0) - qb[c] : qb[c];
		fog_on = zv_b > {3'b0, fog_q, 14'b0};
		fadd = (zv_b >> 14) - 32'(fog_q);
		fsh = c_b.shade + fadd[15:0];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else v_s7 <= vb[0];
	end
	always_ff @(posedge clk) begin
		c_s7 <= c_b;
		rej_s7 <= rej_b;
		zv_s7 <= zv_b;
		sc_s7[0] <= 32'(cx_q) + qs[0];
		sc_s7[1] <= 32'(cy_q) + qs[1];
		sc_s7[2] <= 32'(cx_q) + qs[2];
		sc_s7[3] <= 32'(cy_q) + qs[3];
		if (!c_b.fog) begin
			sh_s7 <= ShadeNeutral;
			fogcull_s7 <= 1'b0;
		end else if (fog_on) begin
			sh_s7 <= fsh;
			fogcull_s7 <= fsh > ShadeCull;
		end else begin
			sh_s7 <= c_b.shade;
			fogcull_s7 <= 1'b0;
		end
	end

	// Stage 8: screen cull and output register.
	logic cull;
	assign cull = rej_s7 || fogcull_s7 ||
		sc_s7[0] >= $signed(32'(ww_q)) || sc_s7[1] >= $signed(32'(wh_q)) ||
		sc_s7[2] < 0 || sc_s7[3] < 0;
	assign in_done = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= v_s7 || (accept && req_type);
	end

	// Loads skip the pipeline: they only issue when it is empty.
	always_ff @(posedge clk) begin
		if (accept && req_type) begin
			visible <= 1'b0;
			depth <= '0; left <= '0; top <= '0; right <= '0; bottom <= '0;
			sprite_out <= '0; shade_out <= '0; colour_kind <= 1'b0;
			load_value <= lval;
		end else if (!v_s7 || c_s7.load || cull) begin
			visible <= 1'b0;
			depth <= '0; left <= '0; top <= '0; right <= '0; bottom <= '0;
			sprite_out <= '0; shade_out <= '0; colour_kind <= 1'b0;
			load_value <= '0;
		end else begin
			visible <= 1'b1;
			depth <= zv_s7;
			left <= sc_s7[0];
			top <= sc_s7[1];
			right <= sc_s7[2];
			bottom <= sc_s7[3];
			sprite_out <= c_s7.idx;
			shade_out <= (c_s7.rgb != '0) ? rgb15(c_s7.rgb) : sh_s7;
			colour_kind <= c_s7.rgb != '0;
			load_value <= '0;
		end
	end

	// A load is only taken when nothing is in flight, so a load and a draw never finish together.
	a_load_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type) |-> !v_s7)
		else $error("load completed alongside a draw");
	a_vis_done: assert property (@(posedge clk) disable iff (!arst_n)
		visible |-> done)
		else $error("visible without done");
	a_load_nodraw: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type) |=> (done && !visible))
		else $error("load result malformed");
endmodule

// ===== rtl/core/spcf_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module spcf_ram #(
	parameter int Width = 16,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/core/spcf_div.sv =====
// Pipelined unsigned divider, one quotient bit per stage.
`timescale 1ns / 1ps
module spcf_div #(
	parameter int NumW = 32,
	parameter int DenW = 32,
	parameter int TagW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [NumW-1:0] num,
	input  logic [DenW-1:0] den,
	input  logic [TagW-1:0] tag_in,
	output logic            out_valid,
	output logic [NumW-1:0] quot,
	output logic [TagW-1:0] tag_out
);
	logic            v_q   [NumW+1];
	logic [NumW-1:0] q_q   [NumW+1];
	logic [DenW:0]   r_q   [NumW+1];
	logic [DenW-1:0] d_q   [NumW+1];
	logic [TagW-1:0] t_q   [NumW+1];

	assign v_q[0] = in_valid;
	assign q_q[0] = num;
	assign r_q[0] = '0;
	assign d_q[0] = den;
	assign t_q[0] = tag_in;

	for (genvar i = 0; i < NumW; i++) begin : g_stage
		logic [DenW:0] trial;
		logic [DenW:0] shifted;
		logic          fits;
		logic          v_s;
		logic [NumW-1:0] q_s;
		logic [DenW:0]   r_s;
		logic [DenW-1:0] d_s;
		logic [TagW-1:0] t_s;

		// Remainder stays below the divisor, so DenW+1 bits hold the shifted value.
		assign shifted = {r_q[i][DenW-1:0], q_q[i][NumW-1]};
		assign fits = shifted >= {1'b0, d_q[i]};
		assign trial = fits ? shifted - {1'b0, d_q[i]} : shifted;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s <= 1'b0;
			end else begin
				v_s <= v_q[i];
			end
		end
		always_ff @(posedge clk) begin
			q_s <= {q_q[i][NumW-2:0], fits};
			r_s <= trial;
			d_s <= d_q[i];
			t_s <= t_q[i];
		end
		assign v_q[i+1] = v_s;
		assign q_q[i+1] = q_s;
		assign r_q[i+1] = r_s;
		assign d_q[i+1] = d_s;
		assign t_q[i+1] = t_s;
	end

	assign out_valid = v_q[NumW];
	assign quot = q_q[NumW];
	assign tag_out = t_q[NumW];
endmodule
